/* hdl/owbm_pkg.sv */
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and codes for the single-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

	typedef logic [3:0] phase_t;
	typedef logic [1:0] kind_t;
	typedef logic [1:0] drive_t;
	typedef logic [2:0] cfg_index_t;

	// bus phases
	localparam phase_t PH_IDLE      = 4'd0;
	localparam phase_t PH_RST_HIGH  = 4'd1;
	localparam phase_t PH_RST_LOW   = 4'd2;
	localparam phase_t PH_RST_REL   = 4'd3;
	localparam phase_t PH_RST_POLL  = 4'd4;
	localparam phase_t PH_BIT_HIGH  = 4'd5;
	localparam phase_t PH_BIT_LOW   = 4'd6;
	localparam phase_t PH_BIT_REL   = 4'd7;
	localparam phase_t PH_RD_WAIT   = 4'd8;
	localparam phase_t PH_RD_SAMPLE = 4'd9;
	localparam phase_t PH_RD_SLOT   = 4'd10;
	localparam phase_t PH_GAP       = 4'd11;

	// command kinds
	localparam kind_t KIND_RESET = 2'd0;
	localparam kind_t KIND_WRITE = 2'd1;
	localparam kind_t KIND_READ  = 2'd2;
	localparam kind_t KIND_NONE  = 2'd3;

	// line drive codes
	localparam drive_t DRV_REL  = 2'd0;
	localparam drive_t DRV_HIGH = 2'd1;
	localparam drive_t DRV_LOW  = 2'd2;

	// configuration register indexes
	localparam cfg_index_t CFG_UNIT_TICKS   = 3'd0;
	localparam cfg_index_t CFG_SHORT_TICKS  = 3'd1;
	localparam cfg_index_t CFG_RESET_LOW    = 3'd2;
	localparam cfg_index_t CFG_RESET_REL    = 3'd3;
	localparam cfg_index_t CFG_WRITE0_LOW   = 3'd4;
	localparam cfg_index_t CFG_SLOT         = 3'd5;
	localparam cfg_index_t CFG_SAMPLE       = 3'd6;

	// configuration reset values
	localparam logic [11:0] UNIT_TICKS_RST  = 12'd10;
	localparam logic [7:0]  SHORT_TICKS_RST = 8'd2;
	localparam logic [7:0]  RESET_LOW_RST   = 8'd49;
	localparam logic [7:0]  RESET_REL_RST   = 8'd6;
	localparam logic [7:0]  WRITE0_LOW_RST  = 8'd7;
	localparam logic [7:0]  SLOT_RST        = 8'd6;
	localparam logic [7:0]  SAMPLE_RST      = 8'd1;

endpackage

/* hdl/one_wire_bus_master.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Tick-timed single-wire bus master: bus reset, write byte, read byte.
// ----------------------------------------------------------------------------
// Every request on the input channel is one tick of bus time: it carries the
// sampled line level and, optionally, a command with its data byte. A command
// is only taken while the master is idle, and its first phase is already
// driven on that tick. For each request exactly one result comes out, giving
// the line drive (released, high, low), busy, done, and the byte from the last
// finished read. The master takes one request per clock cycle while in_stall
// is low; a request passes an input register and then the single step
// stage, where the phase sequencer and its tick/unit counters advance and
// the result register loads. The input register lets a new request in
// while a result is held by a stalled output. Timing registers are written
// through the plain write port and should only change while the master is
// idle; zero in a register whose lower bound is one acts as one.
module one_wire_bus_master
	import owbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd_valid,
	input  logic [1:0]  func,
	input  logic [7:0]  data_byte,
	input  logic        line_level,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  drive_mode,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_value,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [11:0] unit_ticks_q;
	logic [7:0]  short_ticks_q;
	logic [7:0]  reset_low_q;
	logic [7:0]  reset_rel_q;
	logic [7:0]  write0_low_q;
	logic [7:0]  slot_q;
	logic [7:0]  sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q  <= UNIT_TICKS_RST;
			short_ticks_q <= SHORT_TICKS_RST;
			reset_low_q   <= RESET_LOW_RST;
			reset_rel_q   <= RESET_REL_RST;
			write0_low_q  <= WRITE0_LOW_RST;
			slot_q        <= SLOT_RST;
			sample_q      <= SAMPLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UNIT_TICKS:  unit_ticks_q  <= cfg_data;
				CFG_SHORT_TICKS: short_ticks_q <= cfg_data[7:0];
				CFG_RESET_LOW:   reset_low_q   <= cfg_data[7:0];
				CFG_RESET_REL:   reset_rel_q   <= cfg_data[7:0];
				CFG_WRITE0_LOW:  write0_low_q  <= cfg_data[7:0];
				CFG_SLOT:        slot_q        <= cfg_data[7:0];
				CFG_SAMPLE:      sample_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// handshake: input register (s1) feeding the result register
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic       cmd_valid_s1;
	logic [1:0] func_s1;
	logic [7:0] data_byte_s1;
	logic       line_level_s1;
	logic       out_valid_q;
	logic       out_free;
	logic       step;
	logic       in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;      // s1 request is processed
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_valid_s1  <= cmd_valid;
			func_s1       <= func;
			data_byte_s1  <= data_byte;
			line_level_s1 <= line_level;
		end
	end

	// ------------------------------------------------------------------
	// sequencer state
	// ------------------------------------------------------------------
	phase_t      phase_q;
	kind_t       kind_q;
	logic [11:0] tick_q;
	logic [7:0]  unit_q;
	logic [2:0]  bit_q;
	logic [7:0]  shift_q;
	logic [7:0]  last_read_q;

	// state after a possible command start
	phase_t      phase_e;
	kind_t       kind_e;
	logic [11:0] tick_e;
	logic [7:0]  unit_e;
	logic [2:0]  bit_e;
	logic [7:0]  shift_e;

	// next state and result
	phase_t      phase_d;
	logic [11:0] tick_d;
	logic [7:0]  unit_d;
	logic [2:0]  bit_d;
	logic [7:0]  shift_d;
	logic [7:0]  last_read_d;
	drive_t      drive_d;
	logic        busy_d;
	logic        done_d;

	// helpers
	logic        unit_phase;
	logic [7:0]  phase_units;
	phase_t      next_raw;
	phase_t      next_ph;
	logic [11:0] tick_inc;
	logic [7:0]  unit_inc;
	logic [11:0] short_lim;
	logic [11:0] unit_lim;
	logic [7:0]  reset_low_lim;
	logic [7:0]  write0_lim;
	logic        ph_end;

	assign short_lim     = (short_ticks_q == 8'd0) ? 12'd1 : {4'd0, short_ticks_q};
	assign unit_lim      = (unit_ticks_q == 12'd0) ? 12'd1 : unit_ticks_q;
	assign reset_low_lim = (reset_low_q == 8'd0) ? 8'd1 : reset_low_q;
	assign write0_lim    = (write0_low_q == 8'd0) ? 8'd1 : write0_low_q;

	// command start
	always_comb begin
		phase_e = (phase_q > PH_GAP) ? PH_IDLE : phase_q;
		kind_e  = kind_q;
		tick_e  = tick_q;
		unit_e  = unit_q;
		bit_e   = bit_q;
		shift_e = shift_q;
		if (phase_e == PH_IDLE && cmd_valid_s1 && func_s1 != KIND_NONE) begin
			kind_e  = func_s1;
			bit_e   = 3'd0;
			shift_e = (func_s1 == KIND_WRITE) ? data_byte_s1 : 8'd0;
			phase_e = (func_s1 == KIND_RESET) ? PH_RST_HIGH : PH_BIT_HIGH;
			tick_e  = 12'd0;
			unit_e  = 8'd0;
		end
	end

	// phase classification; a zero bit low phase is timed in units
	always_comb begin
		unit_phase = (phase_e == PH_RST_LOW) || (phase_e == PH_RST_REL) ||
			(phase_e == PH_BIT_REL) || (phase_e == PH_RD_WAIT) ||
			(phase_e == PH_RD_SLOT) ||
			(phase_e == PH_BIT_LOW && kind_e == KIND_WRITE && !shift_e[0]);

		case (phase_e)
			PH_RST_LOW: phase_units = reset_low_lim;
			PH_RST_REL: phase_units = reset_rel_q;
			PH_BIT_LOW: phase_units = write0_lim;
			PH_BIT_REL: phase_units = slot_q;
			PH_RD_WAIT: phase_units = sample_q;
			PH_RD_SLOT: phase_units = slot_q;
			default:    phase_units = 8'd0;
		endcase

		case (phase_e)
			PH_RST_HIGH:  next_raw = PH_RST_LOW;
			PH_RST_LOW:   next_raw = PH_RST_REL;
			PH_RST_REL:   next_raw = PH_RST_POLL;
			PH_BIT_HIGH:  next_raw = PH_BIT_LOW;
			PH_BIT_LOW: begin
				if (kind_e == KIND_READ) begin
					next_raw = PH_RD_WAIT;
				end else begin
					next_raw = shift_e[0] ? PH_BIT_REL : PH_GAP;
				end
			end
			PH_BIT_REL:   next_raw = PH_GAP;
			PH_RD_WAIT:   next_raw = PH_RD_SAMPLE;
			PH_RD_SAMPLE: next_raw = PH_RD_SLOT;
			PH_RD_SLOT:   next_raw = PH_GAP;
			default:      next_raw = PH_IDLE;
		endcase

		// a unit-timed phase of zero length is skipped on entry
		case (next_raw)
			PH_RST_REL: next_ph = (reset_rel_q == 8'd0) ? PH_RST_POLL : PH_RST_REL;
			PH_BIT_REL: next_ph = (slot_q == 8'd0) ? PH_GAP : PH_BIT_REL;
			PH_RD_WAIT: next_ph = (sample_q == 8'd0) ? PH_RD_SAMPLE : PH_RD_WAIT;
			PH_RD_SLOT: next_ph = (slot_q == 8'd0) ? PH_GAP : PH_RD_SLOT;
			default:    next_ph = next_raw;
		endcase
	end

	// tick and unit counting
	always_comb begin
		tick_inc = tick_e + 12'd1;
		unit_inc = unit_e + 8'd1;
		ph_end   = 1'b0;
		tick_d   = tick_inc;
		unit_d   = unit_e;
		if (!unit_phase) begin
			ph_end = (tick_inc >= short_lim);
		end else if (tick_inc >= unit_lim) begin
			tick_d = 12'd0;
			unit_d = unit_inc;
			ph_end = (unit_inc >= phase_units);
		end
	end

	// one tick of the sequencer
	always_comb begin
		phase_d     = phase_e;
		bit_d       = bit_e;
		shift_d     = shift_e;
		last_read_d = last_read_q;
		drive_d     = DRV_REL;
		busy_d      = 1'b0;
		done_d      = 1'b0;

		if (phase_e != PH_IDLE) begin
			busy_d = 1'b1;
			if (phase_e == PH_RST_HIGH || phase_e == PH_BIT_HIGH) begin
				drive_d = DRV_HIGH;
			end else if (phase_e == PH_RST_LOW || phase_e == PH_BIT_LOW) begin
				drive_d = DRV_LOW;
			end
		end

		case (phase_e)
			PH_IDLE: ;
			PH_RST_POLL: begin
				if (line_level_s1) begin
					done_d  = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			PH_RD_SAMPLE: begin
				shift_d = {line_level_s1, shift_e[7:1]};
				phase_d = next_ph;
			end
			default: begin
				if (ph_end) begin
					if (phase_e == PH_GAP) begin
						if (kind_e == KIND_WRITE) begin
							shift_d = {1'b0, shift_e[7:1]};
						end
						if (bit_e == 3'd7) begin
							if (kind_e == KIND_READ) begin
								last_read_d = shift_e;
							end
							done_d  = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							bit_d   = bit_e + 3'd1;
							phase_d = PH_BIT_HIGH;
						end
					end else begin
						phase_d = next_ph;
					end
				end
			end
		endcase
	end

	// state registers; every phase change clears the counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			kind_q      <= KIND_RESET;
			tick_q      <= 12'd0;
			unit_q      <= 8'd0;
			bit_q       <= 3'd0;
			shift_q     <= 8'd0;
			last_read_q <= 8'd0;
		end else if (step) begin
			phase_q     <= phase_d;
			kind_q      <= kind_e;
			bit_q       <= bit_d;
			shift_q     <= shift_d;
			last_read_q <= last_read_d;
			if (phase_d != phase_e || phase_e == PH_RD_SAMPLE || done_d) begin
				tick_q <= 12'd0;
				unit_q <= 8'd0;
			end else begin
				tick_q <= tick_d;
				unit_q <= unit_d;
			end
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	logic [1:0] drive_q;
	logic       busy_q;
	logic       done_q;
	logic [7:0] read_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			drive_q <= drive_d;
			busy_q  <= busy_d;
			done_q  <= done_d;
			read_q  <= last_read_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign drive_mode = drive_q;
	assign busy_res   = busy_q;
	assign done_res   = done_q;
	assign read_value = read_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> busy_q)
		else $error("done reported without busy");

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !busy_q |-> drive_q == DRV_REL)
		else $error("line driven while idle");

	a_reset_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RST_HIGH || phase_q == PH_RST_LOW ||
		 phase_q == PH_RST_REL || phase_q == PH_RST_POLL) |-> kind_q == KIND_RESET)
		else $error("reset phase outside a bus reset command");

	a_read_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RD_WAIT || phase_q == PH_RD_SAMPLE ||
		 phase_q == PH_RD_SLOT) |-> kind_q == KIND_READ)
		else $error("read phase outside a read command");

	a_no_step_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> $stable(phase_q) || $past(step))
		else $error("sequencer advanced without a request");

endmodule

/* sim/owbm_checker.sv */
// ----------------------------------------------------------------------------
// owbm_checker
// Tracks the bus master tick by tick and checks every result it returns.
// ----------------------------------------------------------------------------
module owbm_checker
	import owbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        cmd_valid,
	input  logic [1:0]  func,
	input  logic [7:0]  data_byte,
	input  logic        line_level,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  drive_mode,
	input  logic        busy_res,
	input  logic        done_res,
	input  logic [7:0]  read_value,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        wrap_up,
	output int          fail_count
);

	typedef struct packed {
		drive_t     drive;
		logic       busy;
		logic       done;
		logic [7:0] rd_byte;
	} bus_result_t;

	bus_result_t results_due[$];
	bus_result_t seen, want;

	// timing registers
	logic [11:0] t_unit;
	logic [7:0]  t_short, t_rst_low, t_rst_rel, t_w0_low, t_slot, t_sample;

	// sequencer state
	phase_t      ph;
	kind_t       kind;
	logic [11:0] tick_cnt;
	logic [7:0]  unit_cnt;
	logic [2:0]  bit_cnt;
	logic [7:0]  shreg;
	logic [7:0]  last_rd;
	logic        wrapped;

	function automatic int floor_one(int v);
		return (v == 0) ? 1 : v;
	endfunction

	// phases whose length is counted in units rather than short ticks
	function automatic bit unit_timed(phase_t p);
		return p == PH_RST_LOW || p == PH_RST_REL || p == PH_BIT_REL ||
			p == PH_RD_WAIT || p == PH_RD_SLOT ||
			(p == PH_BIT_LOW && kind == KIND_WRITE && !shreg[0]);
	endfunction

	function automatic int units_of(phase_t p);
		case (p)
			PH_RST_LOW: return floor_one(t_rst_low);
			PH_RST_REL: return t_rst_rel;
			PH_BIT_LOW: return floor_one(t_w0_low);
			PH_BIT_REL: return t_slot;
			PH_RD_WAIT: return t_sample;
			PH_RD_SLOT: return t_slot;
			default:    return 0;
		endcase
	endfunction

	function automatic drive_t drive_of(phase_t p);
		if (p == PH_RST_HIGH || p == PH_BIT_HIGH)
			return DRV_HIGH;
		if (p == PH_RST_LOW || p == PH_BIT_LOW)
			return DRV_LOW;
		return DRV_REL;
	endfunction

	function automatic phase_t after_phase(phase_t p);
		case (p)
			PH_RST_HIGH:  return PH_RST_LOW;
			PH_RST_LOW:   return PH_RST_REL;
			PH_RST_REL:   return PH_RST_POLL;
			PH_BIT_HIGH:  return PH_BIT_LOW;
			PH_BIT_LOW: begin
				if (kind == KIND_READ)
					return PH_RD_WAIT;
				return shreg[0] ? PH_BIT_REL : PH_GAP;
			end
			PH_BIT_REL:   return PH_GAP;
			PH_RD_WAIT:   return PH_RD_SAMPLE;
			PH_RD_SAMPLE: return PH_RD_SLOT;
			PH_RD_SLOT:   return PH_GAP;
			default:      return PH_IDLE;
		endcase
	endfunction

	// zero-length unit phases fall straight through
	function automatic void enter_phase(phase_t p);
		while (unit_timed(p) && units_of(p) == 0)
			p = after_phase(p);
		ph = p;
		tick_cnt = '0;
		unit_cnt = '0;
	endfunction

	function automatic bit phase_over();
		tick_cnt = tick_cnt + 1'b1;
		if (!unit_timed(ph))
			return tick_cnt >= floor_one(t_short);
		if (tick_cnt >= floor_one(t_unit)) begin
			tick_cnt = '0;
			unit_cnt = unit_cnt + 1'b1;
			if (unit_cnt >= units_of(ph))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bus_result_t advance_bus_tick(logic cmd, logic [1:0] f,
			logic [7:0] d, logic line);
		bus_result_t r;
		r = '0;
		if (ph == PH_IDLE && cmd && f != KIND_NONE) begin
			kind = f;
			bit_cnt = '0;
			shreg = (f == KIND_WRITE) ? d : 8'h00;
			enter_phase((f == KIND_RESET) ? PH_RST_HIGH : PH_BIT_HIGH);
		end
		if (ph != PH_IDLE) begin
			r.busy = 1'b1;
			r.drive = drive_of(ph);
			if (ph == PH_RST_POLL) begin
				if (line) begin
					r.done = 1'b1;
					enter_phase(PH_IDLE);
				end
			end else if (ph == PH_RD_SAMPLE) begin
				shreg = {line, shreg[7:1]};
				enter_phase(after_phase(ph));
			end else if (phase_over()) begin
				if (ph == PH_GAP) begin
					if (kind == KIND_WRITE)
						shreg = shreg >> 1;
					if (bit_cnt == 3'd7) begin
						if (kind == KIND_READ)
							last_rd = shreg;
						r.done = 1'b1;
						enter_phase(PH_IDLE);
					end else begin
						bit_cnt = bit_cnt + 1'b1;
						enter_phase(PH_BIT_HIGH);
					end
				end else begin
					enter_phase(after_phase(ph));
				end
			end
		end
		r.rd_byte = last_rd;
		return r;
	endfunction

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_unit = UNIT_TICKS_RST;
			t_short = SHORT_TICKS_RST;
			t_rst_low = RESET_LOW_RST;
			t_rst_rel = RESET_REL_RST;
			t_w0_low = WRITE0_LOW_RST;
			t_slot = SLOT_RST;
			t_sample = SAMPLE_RST;
			ph = PH_IDLE;
			kind = KIND_RESET;
			tick_cnt = '0;
			unit_cnt = '0;
			bit_cnt = '0;
			shreg = '0;
			last_rd = '0;
			wrapped = 1'b0;
			fail_count = 0;
			results_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_UNIT_TICKS:  t_unit = cfg_data;
					CFG_SHORT_TICKS: t_short = cfg_data[7:0];
					CFG_RESET_LOW:   t_rst_low = cfg_data[7:0];
					CFG_RESET_REL:   t_rst_rel = cfg_data[7:0];
					CFG_WRITE0_LOW:  t_w0_low = cfg_data[7:0];
					CFG_SLOT:        t_slot = cfg_data[7:0];
					CFG_SAMPLE:      t_sample = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				results_due.push_back(advance_bus_tick(cmd_valid, func, data_byte,
					line_level));
			if (out_valid && !out_stall) begin
				seen = {drive_mode, busy_res, done_res, read_value};
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result: drive %0d busy %0d done %0d read %0d",
						$time, seen.drive, seen.busy, seen.done, seen.rd_byte);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					check_field("drive_mode", want.drive, seen.drive);
					check_field("busy_res", want.busy, seen.busy);
					check_field("done_res", want.done, seen.done);
					check_field("read_value", want.rd_byte, seen.rd_byte);
				end
			end
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (results_due.size() != 0) begin
					$display("%0t: %0d results expected but never returned", $time,
						results_due.size());
					fail_count += results_due.size();
				end
			end
		end
	end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the single-wire bus master.
// ----------------------------------------------------------------------------
// Every request is one bus tick. The stimulus issues whole commands (bus
// reset, write byte, read byte) and then keeps feeding ticks with a random
// line level until the master reports done; ticks in between carry noise
// that must be ignored (commands while busy, func 3, idle payloads).
// Timing registers change only with the master idle and no result pending.
// owbm_checker predicts and compares every result; this module only paces
// the traffic, watches for a hang and prints the verdict.
// ----------------------------------------------------------------------------
module tb;
	import owbm_pkg::*;

	localparam int QUIET_LIMIT = 5000;     // cycles with no handshake at all
	localparam int ITEM_TARGET = 550;      // requests to send over the whole run

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd_valid;
	logic [1:0]  func;
	logic [7:0]  data_byte;
	logic        line_level;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  drive_mode;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_value;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [11:0] cfg_data;
	logic        wrap_up;
	logic        steady;        // no idling on either side while set
	int          fail_count;
	int          sent_reqs;
	int          got_results;
	int          dones_seen;
	int          quiet_cycles;

	one_wire_bus_master u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd_valid  (cmd_valid),
		.func       (func),
		.data_byte  (data_byte),
		.line_level (line_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.drive_mode (drive_mode),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_value (read_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	owbm_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd_valid  (cmd_valid),
		.func       (func),
		.data_byte  (data_byte),
		.line_level (line_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.drive_mode (drive_mode),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_value (read_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.wrap_up    (wrap_up),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stall, none during a steady stretch
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 30);
	end

	// count results and finished commands to pace the stimulus
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_results <= got_results + 1;
			if (done_res)
				dones_seen <= dones_seen + 1;
		end
	end

	// hang watch: any handshake on either channel resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic logic line_at(int high_pct);
		return $urandom_range(99) < high_pct;
	endfunction

	// mix of mostly-low, even and mostly-high lines; never stuck low
	function automatic int line_mix();
		case ($urandom_range(2))
			0:       return 15;
			1:       return 50;
			default: return 85;
		endcase
	endfunction

	// one bus tick: random gaps before it, then hold until taken
	task automatic send_tick(logic cv, logic [1:0] f, logic [7:0] d, logic ln);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd_valid <= cv;
		func <= f;
		data_byte <= d;
		line_level <= ln;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_reqs++;
	endtask

	// issue a command and tick the bus until its done result comes back,
	// or until the request budget of the run is used up
	task automatic run_cmd(kind_t f, logic [7:0] d, int high_pct);
		int start;
		int n;
		logic [1:0] rf;
		logic [7:0] rd;
		start = dones_seen;
		send_tick(1'b1, f, d, line_at(high_pct));
		n = 0;
		while (dones_seen == start && sent_reqs < ITEM_TARGET) begin
			n++;
			rf = 2'($urandom_range(3));
			rd = 8'($urandom);
			// every command lasts at least three ticks, so these hit a busy master
			if (n <= 2 && $urandom_range(2) == 0)
				send_tick(1'b1, rf, rd, line_at(high_pct));
			else if ($urandom_range(9) == 0)
				send_tick(1'b1, KIND_NONE, rd, line_at(high_pct));
			else
				send_tick(1'b0, rf, rd, line_at(high_pct));
		end
	endtask

	// func 3 offered while idle: no command may start
	task automatic offer_invalid(int count);
		repeat (count)
			send_tick(1'b1, KIND_NONE, 8'($urandom), line_at(50));
	endtask

	// stop sending and let every result drain; the master is idle afterward only if its last command finished
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (got_results != sent_reqs)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// 8-bit registers get junk in the unused top bits
	task automatic write_reg(cfg_index_t idx, logic [11:0] v);
		logic [3:0] junk;
		junk = 4'($urandom_range(15));
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= (idx == CFG_UNIT_TICKS) ? v : {junk, v[7:0]};
	endtask

	task automatic set_timing(logic [11:0] unit, logic [7:0] shrt, logic [7:0] rst_low,
			logic [7:0] rst_rel, logic [7:0] w0_low, logic [7:0] slot, logic [7:0] sample);
		settle();
		write_reg(CFG_UNIT_TICKS, unit);
		write_reg(CFG_SHORT_TICKS, {4'h0, shrt});
		write_reg(CFG_RESET_LOW, {4'h0, rst_low});
		write_reg(CFG_RESET_REL, {4'h0, rst_rel});
		write_reg(CFG_WRITE0_LOW, {4'h0, w0_low});
		write_reg(CFG_SLOT, {4'h0, slot});
		write_reg(CFG_SAMPLE, {4'h0, sample});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [11:0] r_unit;
		logic [7:0]  r_short;
		kind_t       r_kind;

		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd_valid = 1'b0;
		func = KIND_RESET;
		data_byte = 8'h00;
		line_level = 1'b0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_UNIT_TICKS;
		cfg_data = '0;
		wrap_up = 1'b0;
		steady = 1'b0;
		sent_reqs = 0;
		got_results = 0;
		dones_seen = 0;
		quiet_cycles = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// all zero: unit, short and low lengths act as one, other phases skipped
		set_timing(12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		offer_invalid(4);
		run_cmd(KIND_RESET, 8'h00, 15);     // line mostly low: longer reset poll
		run_cmd(KIND_WRITE, 8'h00, 50);
		run_cmd(KIND_WRITE, 8'hFF, 50);
		run_cmd(KIND_READ, 8'h00, 100);     // reads back all ones
		run_cmd(KIND_READ, 8'h00, 0);       // reads back all zeros

		// one-tick units, several units per phase, no idling on either side
		set_timing(12'd1, 8'd1, 8'd3, 8'd2, 8'd3, 8'd2, 8'd2);
		steady <= 1'b1;
		run_cmd(KIND_RESET, 8'h00, 50);
		run_cmd(KIND_WRITE, 8'h5A, 50);
		run_cmd(KIND_READ, 8'h00, 50);
		steady <= 1'b0;

		// two-tick units and short phases; reset release and sample skipped
		set_timing(12'd2, 8'd2, 8'd2, 8'd0, 8'd1, 8'd1, 8'd0);
		run_cmd(KIND_RESET, 8'h00, 85);
		run_cmd(KIND_WRITE, 8'h3C, 50);
		run_cmd(KIND_READ, 8'h00, 50);

		// --- random: short timings keep commands quick ---
		while (sent_reqs < ITEM_TARGET) begin
			r_unit = 12'($urandom_range(3));
			r_short = 8'($urandom_range(2));
			set_timing(r_unit, r_short, 8'($urandom_range(2)), 8'($urandom_range(2)),
				8'($urandom_range(2)), 8'($urandom_range(2)), 8'($urandom_range(2)));
			repeat (4) begin
				if (sent_reqs < ITEM_TARGET) begin
					r_kind = 2'($urandom_range(2));
					run_cmd(r_kind, 8'($urandom), line_mix());
				end
			end
		end

		steady <= 1'b0;
		settle();
		repeat (8) @(negedge clk);
		wrap_up <= 1'b1;
		@(negedge clk);
		@(negedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
